### rtl/additive_lagged_fibonacci_rng_top_macros.svh
// Assertion macros shared by the checker.
`ifndef ADDITIVE_LAGGED_FIBONACCI_RNG_TOP_MACROS_SVH
`define ADDITIVE_LAGGED_FIBONACCI_RNG_TOP_MACROS_SVH

// Check outside reset.
`define ALFR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check at every edge, reset included.
`define ALFR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/alfr_pkg.sv
package alfr_pkg;

   localparam int TABLE_LEN     = 55;
   localparam int MAX_DICE      = 255;
   localparam int IDX_W         = $clog2(TABLE_LEN);
   localparam int COUNT_W       = $clog2(MAX_DICE + 1);
   localparam int WORD_W        = 30;
   localparam int RAW_W         = 24;
   localparam int VALUE_W       = 29;
   localparam int PARTNER_START = TABLE_LEN - 24;

   localparam logic signed [31:0] RANGE_CAP  = 32'sd1000000;
   localparam logic signed [31:0] PERCENT_LO = 32'sd1;
   localparam logic signed [31:0] PERCENT_HI = 32'sd99 + 32'sd1;
   localparam logic signed [31:0] RAW_MAX    = 32'sd16777215;

   localparam logic [2:0] OP_SEED    = 3'd0;
   localparam logic [2:0] OP_RAW     = 3'd1;
   localparam logic [2:0] OP_RANGE   = 3'd2;
   localparam logic [2:0] OP_PERCENT = 3'd3;
   localparam logic [2:0] OP_LOWBITS = 3'd4;
   localparam logic [2:0] OP_DICE    = 3'd5;

   typedef struct packed {
      logic capture;
      logic setup1;
      logic setup2;
      logic seed_step;
      logic draw_read;
      logic draw_sum;
      logic draw_check;
   } cmd_type;

   typedef struct packed {
      logic seed;
      logic no_draw;
      logic seed_last;
      logic accept;
      logic last_draw;
   } status_type;

endpackage

### rtl/alfr_ram.sv
module alfr_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 55
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

### rtl/alfr_datapath.sv
module alfr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  alfr_pkg::cmd_type   cmd,
   output alfr_pkg::status_type status,
   input  logic [2:0]          req_op,
   input  logic [31:0]         req_seed_value,
   input  logic signed [31:0]  req_lower_bound,
   input  logic signed [31:0]  req_upper_bound,
   input  logic [4:0]          req_bit_count,
   input  logic [7:0]          req_dice_count,
   input  logic [19:0]         req_dice_faces,
   output logic signed [28:0]  rsp_value
);

   import alfr_pkg::*;

   function automatic logic [31:0] fill_right(input logic [31:0] v);
      logic [31:0] f;
      f = v;
      f = f | (f >> 1);
      f = f | (f >> 2);
      f = f | (f >> 4);
      f = f | (f >> 8);
      f = f | (f >> 16);
      return f;
   endfunction

   function automatic logic req_lower_c_sel(input logic signed [31:0] v);
      return v > RANGE_CAP;
   endfunction

   logic [2:0]          op_ff;
   logic [WORD_W-1:0]   seed_ff;
   logic signed [31:0]  lower_ff;
   logic signed [31:0]  upper_ff;
   logic [4:0]          bit_count_ff;
   logic [7:0]          dice_count_ff;
   logic [19:0]         faces_ff;

   logic signed [31:0]  lo_ff, lo_in;
   logic signed [31:0]  hi_ff, hi_in;
   logic [31:0]         span_ff, span_in;
   logic [RAW_W-1:0]    mask_ff, mask_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [IDX_W-1:0]    wi_ff, wi_in;
   logic [IDX_W-1:0]    pi_ff, pi_in;
   logic [TABLE_LEN-1:0] valid_ff;
   logic [IDX_W-1:0]    seed_cnt_ff;
   logic [WORD_W-1:0]   p1_ff, p2_ff;
   logic                va_ff, vb_ff;
   logic [RAW_W-1:0]    raw_ff;

   logic signed [31:0]  lower_c, upper_c;
   logic [COUNT_W-1:0]  dice_sat;
   logic [IDX_W-1:0]    a_idx, b_idx;
   logic [WORD_W-1:0]   rd_a, rd_b, da, db, sum;
   logic [WORD_W-1:0]   seed_word;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic [RAW_W-1:0]    pick;
   logic                accept;
   logic [31:0]         filled;

   assign lower_c  = (req_lower_c_sel(lower_ff)) ? RANGE_CAP : lower_ff;
   assign upper_c  = (req_lower_c_sel(upper_ff)) ? RANGE_CAP : upper_ff;
   assign dice_sat = (int'(dice_count_ff) > MAX_DICE) ? COUNT_W'(MAX_DICE)
                                                      : COUNT_W'(dice_count_ff);

   always_comb begin
      case (op_ff)
         OP_RANGE: begin
            if (lower_c > upper_c) begin
               lo_in = upper_c;
               hi_in = lower_c;
            end else begin
               lo_in = lower_c;
               hi_in = upper_c;
            end
         end
         OP_PERCENT: begin
            lo_in = PERCENT_LO;
            hi_in = PERCENT_HI;
         end
         OP_DICE: begin
            lo_in = 32'sd1;
            hi_in = (faces_ff > 20'(RANGE_CAP)) ? RANGE_CAP : signed'(32'(faces_ff));
         end
         default: begin
            lo_in = 32'sd0;
            hi_in = RAW_MAX;
         end
      endcase
   end

   assign span_in = $unsigned(hi_ff - lo_ff);
   assign filled  = fill_right(span_in);

   always_comb begin
      case (op_ff)
         OP_LOWBITS: begin
            if (int'(bit_count_ff) >= RAW_W) begin
               mask_in = '1;
            end else begin
               mask_in = (RAW_W'(1) << bit_count_ff) - RAW_W'(1);
            end
         end
         OP_RAW: begin
            mask_in = '1;
         end
         default: begin
            mask_in = (|filled[31:RAW_W]) ? '1 : filled[RAW_W-1:0];
         end
      endcase
   end

   assign a_idx = (int'(wi_ff) < TABLE_LEN) ? wi_ff : '0;
   assign b_idx = (int'(pi_ff) < TABLE_LEN) ? pi_ff : '0;
   assign da    = va_ff ? rd_a : '0;
   assign db    = vb_ff ? rd_b : '0;
   assign sum   = WORD_W'({1'b0, da} + {1'b0, db});

   always_comb begin
      if (seed_cnt_ff == '0) begin
         seed_word = seed_ff;
      end else if (seed_cnt_ff == IDX_W'(1)) begin
         seed_word = WORD_W'(1);
      end else begin
         seed_word = WORD_W'({1'b0, p1_ff} + {1'b0, p2_ff});
      end
   end

   assign wr_en   = cmd.seed_step | cmd.draw_sum;
   assign wr_addr = cmd.seed_step ? seed_cnt_ff : a_idx;
   assign wr_data = cmd.seed_step ? seed_word : sum;

   assign pick   = raw_ff & mask_ff;
   assign accept = {{(32-RAW_W){1'b0}}, pick} <= span_ff;

   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      if (cmd.setup2) begin
         count_in = (op_ff == OP_DICE) ? dice_sat : COUNT_W'(1);
         if (op_ff == OP_DICE && faces_ff == 20'd1) begin
            acc_in = VALUE_W'(dice_sat);
         end else if (op_ff == OP_RANGE && hi_ff == lo_ff) begin
            acc_in = lo_ff[VALUE_W-1:0];
         end else begin
            acc_in = '0;
         end
      end else if (cmd.draw_check && accept) begin
         acc_in   = acc_ff + lo_ff[VALUE_W-1:0] + VALUE_W'(pick);
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      wi_in = wi_ff;
      pi_in = pi_ff;
      if (cmd.seed_step && status.seed_last) begin
         wi_in = '0;
         pi_in = IDX_W'(PARTNER_START);
      end else if (cmd.draw_sum) begin
         wi_in = (int'(a_idx) == TABLE_LEN - 1) ? '0 : a_idx + IDX_W'(1);
         pi_in = (int'(b_idx) == TABLE_LEN - 1) ? '0 : b_idx + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff    <= '0;
         pi_ff    <= '0;
         valid_ff <= '0;
      end else begin
         wi_ff <= wi_in;
         pi_ff <= pi_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff         <= req_op;
         seed_ff       <= req_seed_value[WORD_W-1:0];
         lower_ff      <= req_lower_bound;
         upper_ff      <= req_upper_bound;
         bit_count_ff  <= req_bit_count;
         dice_count_ff <= req_dice_count;
         faces_ff      <= req_dice_faces;
      end
      if (cmd.setup1) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (cmd.setup2) begin
         span_ff     <= span_in;
         mask_ff     <= mask_in;
         seed_cnt_ff <= '0;
      end
      if (cmd.seed_step) begin
         seed_cnt_ff <= seed_cnt_ff + IDX_W'(1);
         p1_ff       <= seed_word;
         p2_ff       <= p1_ff;
      end
      if (cmd.draw_read) begin
         va_ff <= valid_ff[a_idx];
         vb_ff <= valid_ff[b_idx];
      end
      if (cmd.draw_sum) begin
         raw_ff <= sum[WORD_W-1:WORD_W-RAW_W];
      end
      acc_ff   <= acc_in;
      count_ff <= count_in;
   end

   alfr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_LEN)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (a_idx),
      .rd_data_a (rd_a),
      .rd_addr_b (b_idx),
      .rd_data_b (rd_b)
   );

   assign status.seed      = (op_ff == OP_SEED);
   assign status.no_draw   = (op_ff > OP_DICE)
                           | (op_ff == OP_RANGE && hi_ff == lo_ff)
                           | (op_ff == OP_DICE && (faces_ff <= 20'd1 || dice_sat == '0));
   assign status.seed_last = (int'(seed_cnt_ff) == TABLE_LEN - 1);
   assign status.accept    = accept;
   assign status.last_draw = (count_ff == COUNT_W'(1));

   assign rsp_value = signed'(acc_ff);

endmodule

### rtl/alfr_ctrl.sv
module alfr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output alfr_pkg::cmd_type    cmd,
   input  alfr_pkg::status_type status
);

   import alfr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SETUP1 = 3'd1;
   localparam logic [2:0] S_SETUP2 = 3'd2;
   localparam logic [2:0] S_SEED   = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_SUM    = 3'd5;
   localparam logic [2:0] S_CHECK  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       take;

   assign busy       = (state_ff != S_IDLE) && (state_ff != S_DONE);
   assign rsp_strobe = (state_ff == S_DONE);
   assign take       = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE, S_DONE: begin
            state_in = take ? S_SETUP1 : S_IDLE;
         end
         S_SETUP1: begin
            state_in = S_SETUP2;
         end
         S_SETUP2: begin
            if (status.seed) begin
               state_in = S_SEED;
            end else if (status.no_draw) begin
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_SEED: begin
            if (status.seed_last) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = (status.accept && status.last_draw) ? S_DONE : S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.capture    = take;
   assign cmd.setup1     = (state_ff == S_SETUP1);
   assign cmd.setup2     = (state_ff == S_SETUP2);
   assign cmd.seed_step  = (state_ff == S_SEED);
   assign cmd.draw_read  = (state_ff == S_READ);
   assign cmd.draw_sum   = (state_ff == S_SUM);
   assign cmd.draw_check = (state_ff == S_CHECK);

endmodule

### rtl/additive_lagged_fibonacci_rng_top.sv
// Channel   | Handshake                   | Payload
// request   | start / busy                | req_op, req_seed_value, req_lower_bound,
//           |                             | req_upper_bound, req_bit_count,
//           |                             | req_dice_count, req_dice_faces
// response  | rsp_strobe (one cycle)      | rsp_value
//
// A request is taken when start is high and busy is low; the setup steps come
// first, then for each draw attempt a table read, an add and write back, and a
// range check, then the result with the strobe.
// A seed request writes the 55 table entries one per cycle, then strobes.
// Requests with no draw strobe right after setup; the next request may enter
// in the strobe cycle. Reset clears the indices and marks every entry as zero.
// The receiver cannot stall: each result is shown for exactly one cycle.
module additive_lagged_fibonacci_rng_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic [31:0]        req_seed_value,
   input  logic signed [31:0] req_lower_bound,
   input  logic signed [31:0] req_upper_bound,
   input  logic [4:0]         req_bit_count,
   input  logic [7:0]         req_dice_count,
   input  logic [19:0]        req_dice_faces,
   output logic               rsp_strobe,
   output logic signed [28:0] rsp_value
);

   import alfr_pkg::*;

   cmd_type    cmd;
   status_type status;

   alfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   alfr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_seed_value  (req_seed_value),
      .req_lower_bound (req_lower_bound),
      .req_upper_bound (req_upper_bound),
      .req_bit_count   (req_bit_count),
      .req_dice_count  (req_dice_count),
      .req_dice_faces  (req_dice_faces),
      .rsp_value       (rsp_value)
   );

endmodule

### rtl/alfr_checker.sv
`include "additive_lagged_fibonacci_rng_top_macros.svh"

module alfr_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   `ALFR_ASSERT(a_take_busy, (start && !busy) |=> busy, "busy low after a request was taken")
   `ALFR_ASSERT(a_no_early, (start && !busy) |=> !rsp_strobe, "strobe right after a request")
   `ALFR_ASSERT(a_one_cycle, rsp_strobe |=> !rsp_strobe, "strobe longer than one cycle")
   `ALFR_ASSERT(a_after_busy, rsp_strobe |-> ($past(busy) && !busy), "strobe without work")
   `ALFR_ASSERT_ALWAYS(a_reset, reset |=> (!busy && !rsp_strobe), "not idle after reset")

endmodule

bind additive_lagged_fibonacci_rng_top alfr_checker u_checker (.*);

### verif/additive_lagged_fibonacci_rng_top_tb.sv
`timescale 1ns / 100ps

module additive_lagged_fibonacci_rng_top_tb;
   import alfr_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         TAIL_CYCLES = 100;
   localparam int         RANDOM_REQUESTS = 1150;

   typedef struct packed {
      logic [2:0]         op;
      logic [31:0]        seed;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic [4:0]         bits;
      logic [7:0]         dcount;
      logic [19:0]        dfaces;
      logic               hold;
   } request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_op = '0;
   logic [31:0]        req_seed_value = '0;
   logic signed [31:0] req_lower_bound = '0;
   logic signed [31:0] req_upper_bound = '0;
   logic [4:0]         req_bit_count = '0;
   logic [7:0]         req_dice_count = '0;
   logic [19:0]        req_dice_faces = '0;
   logic               rsp_strobe;
   logic signed [28:0] rsp_value;

   request_type            queued_requests[$];
   logic signed [28:0]     pending_values[$];
   int                     requests_taken = 0;
   int                     results_seen = 0;
   int                     mismatches = 0;
   int                     idle_cycles = 0;

   logic [29:0]            lag_words[TABLE_LEN];
   int unsigned            wr_idx;
   int unsigned            tap_idx;

   additive_lagged_fibonacci_rng_top u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_seed_value  (req_seed_value),
      .req_lower_bound (req_lower_bound),
      .req_upper_bound (req_upper_bound),
      .req_bit_count   (req_bit_count),
      .req_dice_count  (req_dice_count),
      .req_dice_faces  (req_dice_faces),
      .rsp_strobe      (rsp_strobe),
      .rsp_value       (rsp_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [23:0] next_raw();
      int unsigned a;
      int unsigned b;
      logic [29:0] sum;
      a = (wr_idx < TABLE_LEN) ? wr_idx : 0;
      b = (tap_idx < TABLE_LEN) ? tap_idx : 0;
      sum = lag_words[a] + lag_words[b];
      lag_words[a] = sum;
      wr_idx = (a + 1 >= TABLE_LEN) ? 0 : a + 1;
      tap_idx = (b + 1 >= TABLE_LEN) ? 0 : b + 1;
      return sum[29:6];
   endfunction

   function automatic longint span_pick(longint lo, longint hi);
      longint swap;
      longint span;
      longint power;
      longint pick;
      if (hi > longint'(RANGE_CAP)) hi = longint'(RANGE_CAP);
      if (lo > longint'(RANGE_CAP)) lo = longint'(RANGE_CAP);
      if (lo > hi) begin
         swap = lo;
         lo = hi;
         hi = swap;
      end
      span = hi - lo + 1;
      if (span <= 1) return lo;
      power = 2;
      while (power < span) power = power << 1;
      do begin
         pick = longint'(next_raw()) & (power - 1);
      end while (pick >= span);
      return lo + pick;
   endfunction

   function automatic logic signed [28:0] predict_value(request_type r);
      longint      v;
      longint      p;
      longint      count;
      int unsigned k;
      v = 0;
      case (r.op)
         OP_SEED: begin
            lag_words[0] = r.seed[29:0];
            lag_words[1] = 30'd1;
            for (k = 2; k < TABLE_LEN; k++) lag_words[k] = lag_words[k-1] + lag_words[k-2];
            wr_idx = 0;
            tap_idx = PARTNER_START;
         end
         OP_RAW: v = longint'(next_raw());
         OP_RANGE: v = span_pick(longint'($signed(r.lo)), longint'($signed(r.hi)));
         OP_PERCENT: begin
            do begin
               p = longint'(next_raw()) & 127;
            end while (p > 99);
            v = p + 1;
         end
         OP_LOWBITS: v = longint'(next_raw()) & ((longint'(1) << r.bits) - 1);
         OP_DICE: begin
            count = (r.dcount > MAX_DICE) ? MAX_DICE : r.dcount;
            if (r.dfaces == 0) v = 0;
            else if (r.dfaces == 1) v = count;
            else for (k = 0; k < count; k++) v += span_pick(1, longint'(r.dfaces));
         end
         default: v = 0;
      endcase
      return v[28:0];
   endfunction

   task automatic add_req(logic [2:0] op, logic [31:0] seed, logic signed [31:0] lo,
                          logic signed [31:0] hi, logic [4:0] bits, logic [7:0] dcount,
                          logic [19:0] dfaces, logic hold);
      request_type r;
      r.op = op;
      r.seed = seed;
      r.lo = lo;
      r.hi = hi;
      r.bits = bits;
      r.dcount = dcount;
      r.dfaces = dfaces;
      r.hold = hold;
      queued_requests.push_back(r);
   endtask

   task automatic report_mismatch(string what, logic signed [28:0] want,
                                  logic signed [28:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s at result %0d: expected %0d, got %0d", what, results_seen, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            pending_values.push_back(predict_value(queued_requests.pop_front()));
            requests_taken <= requests_taken + 1;
         end
         if (queued_requests.size() != 0 &&
             (!queued_requests[0].hold || (!start && requests_taken == results_seen)) &&
             ((requests_taken >= 500 && requests_taken < 750) ||
              $urandom_range(99) >= 34)) begin
            start           <= 1'b1;
            req_op          <= queued_requests[0].op;
            req_seed_value  <= queued_requests[0].seed;
            req_lower_bound <= queued_requests[0].lo;
            req_upper_bound <= queued_requests[0].hi;
            req_bit_count   <= queued_requests[0].bits;
            req_dice_count  <= queued_requests[0].dcount;
            req_dice_faces  <= queued_requests[0].dfaces;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (pending_values.size() == 0) begin
            report_mismatch("unexpected value", '0, rsp_value);
         end else begin
            if (rsp_value !== pending_values[0])
               report_mismatch("value mismatch", pending_values[0], rsp_value);
            void'(pending_values.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      request_type r;
      int          n;
      int          pick;
      for (n = 0; n < TABLE_LEN; n++) lag_words[n] = '0;
      wr_idx = 0;
      tap_idx = 0;

      // unseeded table
      add_req(OP_RAW, 32'd0, 32'sd0, 32'sd0, 5'd24, 8'd0, 20'd0, 1'b0);
      add_req(OP_PERCENT, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_RANGE, 32'd0, -32'sd5, 32'sd5, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_DICE, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd3, 20'd6, 1'b0);
      add_req(OP_SPARE_A, 32'hFFFF_FFFF, 32'sd1, 32'sd2, 5'd31, 8'd255, 20'hFFFFF, 1'b0);
      add_req(OP_SPARE_B, 32'h1234_5678, 32'sd1, 32'sd2, 5'd31, 8'd255, 20'hFFFFF, 1'b0);
      add_req(OP_SEED, 32'hFFFF_FFFF, 32'sd0, 32'sd0, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_RAW, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_RANGE, 32'd0, 32'sd7, 32'sd7, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_RANGE, 32'd0, 32'sd100, -32'sd100, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_RANGE, 32'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_RANGE, 32'd0, 32'sh7FFF_FFFF, 32'sd2000000, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_RANGE, 32'd0, 32'sd0, 32'sd1, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_SEED, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_PERCENT, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_LOWBITS, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd0, 20'd0, 1'b0);
      add_req(OP_LOWBITS, 32'd0, 32'sd0, 32'sd0, 5'd23, 8'd0, 20'd0, 1'b0);
      add_req(OP_LOWBITS, 32'd0, 32'sd0, 32'sd0, 5'd24, 8'd0, 20'd0, 1'b0);
      add_req(OP_LOWBITS, 32'd0, 32'sd0, 32'sd0, 5'd31, 8'd0, 20'd0, 1'b0);
      add_req(OP_DICE, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd255, 20'd0, 1'b0);
      add_req(OP_DICE, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd255, 20'd1, 1'b0);
      add_req(OP_DICE, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd0, 20'd6, 1'b0);
      add_req(OP_DICE, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd255, 20'd6, 1'b0);
      add_req(OP_DICE, 32'd0, 32'sd0, 32'sd0, 5'd0, 8'd4, 20'hFFFFF, 1'b0);
      add_req(OP_SEED, 32'h2AAA_5555, 32'sd0, 32'sd0, 5'd0, 8'd0, 20'd0, 1'b1);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         r.seed = $urandom;
         r.lo = $urandom;
         r.hi = $urandom;
         r.bits = 5'($urandom_range(31));
         r.dcount = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(12));
         case ($urandom_range(4))
            0, 1: r.dfaces = 20'($urandom_range(20));
            2, 3: r.dfaces = 20'($urandom_range(1000000));
            default: r.dfaces = 20'($urandom);
         endcase
         case ($urandom_range(3))
            0, 1: begin
               r.lo = int'($urandom_range(2000)) - 1000;
               r.hi = r.lo + int'($urandom_range(1500)) - 300;
            end
            2: begin
               r.lo = 1000000 - int'($urandom_range(2000));
               r.hi = 1000000 + int'($urandom_range(5000)) - 2000;
            end
            default: ;
         endcase
         pick = $urandom_range(99);
         if (pick < 4) r.op = OP_SEED;
         else if (pick < 20) r.op = OP_RAW;
         else if (pick < 40) r.op = OP_RANGE;
         else if (pick < 55) r.op = OP_PERCENT;
         else if (pick < 72) r.op = OP_LOWBITS;
         else if (pick < 94) r.op = OP_DICE;
         else r.op = $urandom_range(1) ? OP_SPARE_B : OP_SPARE_A;
         r.hold = (n % 300 == 150);
         queued_requests.push_back(r);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (queued_requests.size() != 0 || start || requests_taken != results_seen)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_values.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/alfr_pkg.sv
rtl/alfr_ram.sv
rtl/alfr_datapath.sv
rtl/alfr_ctrl.sv
rtl/additive_lagged_fibonacci_rng_top.sv
rtl/alfr_checker.sv
verif/additive_lagged_fibonacci_rng_top_tb.sv
